// File: rtl/fdsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_pkg
// Shared types, constants and the segment lookup for the display framer.
// ----------------------------------------------------------------------------
package fdsd_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int CSR_WIDTH = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int SYMBOL_COUNT = 13;

   localparam logic [7:0] DATA_CMD = 8'h40;
   localparam logic [7:0] ADDR_CMD = 8'hC0;
   localparam logic [7:0] CTRL_BASE = 8'h80;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [15:0] DIV10_MUL = 16'hCCCD;
   localparam int DIV10_SHIFT = 19;

   localparam logic [0:0] CSR_BRIGHTNESS = 1'd0;
   localparam logic [0:0] CSR_DISPLAY_ON = 1'd1;

   localparam logic [2:0] BRIGHTNESS_RESET = 3'd7;
   localparam logic DISPLAY_ON_RESET = 1'b1;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_BYTE  = 2'd1,
      KIND_STOP  = 2'd2
   } symbol_kind_type;

   typedef struct packed {
      logic [2:0] brightness;
      logic display_on;
   } cfg_type;

   // seg[0] is the thousands digit, seg[3] the ones digit
   typedef struct packed {
      logic [3:0][7:0] seg;
   } entry_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'h3F;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5B;
         4'd3: code = 8'h4F;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6D;
         4'd6: code = 8'h7D;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7F;
         4'd9: code = 8'h6F;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// File: rtl/fdsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_if
// Request and response channel interfaces of the display framer.
// ----------------------------------------------------------------------------
interface fdsd_req_if;
   logic valid;
   logic ready;
   logic [15:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface fdsd_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] symbol_kind;
   logic [7:0] byte_value;
   logic last;

   modport source (output valid, output symbol_kind, output byte_value, output last,
                   input ready);
   modport sink (input valid, input symbol_kind, input byte_value, input last,
                 output ready);
endinterface

// File: rtl/fdsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_front
// Accepts a value and splits it into four segment codes, one digit a cycle.
// ----------------------------------------------------------------------------
module fdsd_front
   import fdsd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   fdsd_req_if.sink req_bus,
   output logic push_valid,
   input  logic push_ready,
   output entry_type push_entry
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_PUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   entry_type entry_ff, entry_in;

   logic accept;
   logic [31:0] prod;
   logic [12:0] quot;
   logic [15:0] quot10;
   logic [15:0] diff;

   assign push_valid = (state_ff == ST_PUSH);
   assign push_entry = entry_ff;
   assign req_bus.ready = (state_ff == ST_IDLE) || ((state_ff == ST_PUSH) && push_ready);
   assign accept = req_bus.valid && req_bus.ready;

   assign prod = rem_ff * DIV10_MUL;
   assign quot = prod[31:DIV10_SHIFT];
   assign quot10 = {quot[12:0], 3'b000} + {2'b00, quot[12:0], 1'b0};
   assign diff = rem_ff - quot10;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      entry_in = entry_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            entry_in.seg[~cnt_ff] = seg_code(diff[3:0]);
            rem_in = {3'b000, quot};
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (push_ready) begin
               state_in = accept ? ST_CONV : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (accept) begin
         rem_in = req_bus.value;
         cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      entry_ff <= entry_in;
   end

endmodule

// File: rtl/fdsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_queue
// Short queue of converted digit sets between front and back.
// ----------------------------------------------------------------------------
module fdsd_queue
   import fdsd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  entry_type push_entry,
   output logic pop_valid,
   input  logic pop,
   output entry_type pop_entry
);

   localparam int PTR_WIDTH = $clog2(DEPTH);
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   entry_type mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid = (cnt_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_CNT) else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff)) else $error("queue pointers apart");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push && cnt_ff == CNT_WIDTH'(1)) |=> !pop_valid)
      else $error("queue not empty after last pop");
`endif

endmodule

// File: rtl/fdsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdsd_back
// Symbol sequencer: emits the thirteen bus symbols of one display update.
// ----------------------------------------------------------------------------
module fdsd_back
   import fdsd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic pop_valid,
   output logic pop,
   input  entry_type pop_entry,
   fdsd_rsp_if.source rsp_bus
);

   localparam logic [3:0] LAST_SYM = 4'(SYMBOL_COUNT - 1);

   logic [3:0] sym_ff;
   logic rsp_valid_ff;
   symbol_kind_type kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;
   logic step;
   logic [7:0] ctrl;

   assign step = pop_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop = step && (sym_ff == LAST_SYM);
   assign ctrl = CTRL_BASE | {4'b0000, cfg.display_on, cfg.brightness};

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.symbol_kind = kind_ff;
   assign rsp_bus.byte_value = byte_ff;
   assign rsp_bus.last = last_ff;

   always_comb begin
      kind_in = KIND_BYTE;
      byte_in = 8'h00;
      last_in = 1'b0;
      case (sym_ff)
         4'd0, 4'd3, 4'd10: kind_in = KIND_START;
         4'd1: byte_in = DATA_CMD;
         4'd2, 4'd9: kind_in = KIND_STOP;
         4'd4: byte_in = ADDR_CMD;
         4'd5: byte_in = pop_entry.seg[0];
         4'd6: byte_in = pop_entry.seg[1];
         4'd7: byte_in = pop_entry.seg[2];
         4'd8: byte_in = pop_entry.seg[3];
         4'd11: byte_in = ctrl;
         4'd12: begin
            kind_in = KIND_STOP;
            last_in = 1'b1;
         end
         default: kind_in = KIND_STOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            sym_ff <= (sym_ff == LAST_SYM) ? '0 : sym_ff + 4'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

`ifndef ASSERT_OFF
   a_sym_range: assert property (@(posedge clock) disable iff (reset)
      sym_ff <= LAST_SYM) else $error("symbol counter out of range");
   a_last_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (kind_ff == KIND_STOP && byte_ff == 8'h00))
      else $error("last beat is not a stop");
   a_wrap_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid_ff && last_ff && sym_ff == '0))
      else $error("entry released off the final stop");
`endif

endmodule

// File: rtl/four_digit_segment_display_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_digit_segment_display_framer
// Turns a 16-bit number into the thirteen bus symbols of one display update.
// ----------------------------------------------------------------------------
// Each accepted value yields thirteen response beats, one per cycle when the
// sink keeps ready high: start, 0x40, stop, start, 0xC0, four segment bytes
// (thousands first), stop, start, control byte, stop with last set. The
// sustained rate is set by the symbol sequencer in the back end, which only
// moves to the next digit set after the final stop of the current one. The
// front end splits a value into digits (one divide-by-ten per cycle) and
// hands it over through a small queue; the first beat of a value goes out
// once its digit set sits in the queue. brightness and display_on are
// sampled when the control byte goes out.
module four_digit_segment_display_framer
   import fdsd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   fdsd_req_if.sink req_bus,
   fdsd_rsp_if.source rsp_bus,
   input  logic csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [CSR_WIDTH-1:0] csr_write_data
);

   cfg_type cfg_ff;
   logic push_valid, push_ready;
   entry_type push_entry;
   logic pop_valid, pop;
   entry_type pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness <= BRIGHTNESS_RESET;
         cfg_ff.display_on <= DISPLAY_ON_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BRIGHTNESS: cfg_ff.brightness <= csr_write_data[2:0];
            CSR_DISPLAY_ON: cfg_ff.display_on <= csr_write_data[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   fdsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   fdsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   fdsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

endmodule
